// File: design/lprt_pkg.sv
// Shared types and constants for the long-press run timer.
// Holds the transfer payload structs, mode codes and the reciprocal divide constants.
`default_nettype none
package lprt_pkg;

  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned SEC_W = 26;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_CONFIRM = 8'd1;

  localparam logic [7:0] PRESS_THRESHOLD_RST = 8'd69;
  localparam logic [7:0] STOP_CONFIRM_RST = 8'd50;
  localparam logic [7:0] PRESS_MAX = 8'd255;

  localparam logic [1:0] TM_IDLE = 2'd0;
  localparam logic [1:0] TM_RUNNING = 2'd1;
  localparam logic [1:0] TM_STOPPED = 2'd2;

  // Division by TICKS_PER_SECOND as a multiply by a truncated reciprocal.
  // The estimate is low by at most one and is fixed by one compare.
  localparam int unsigned DIV_LOG = $clog2(TICKS_PER_SECOND);
  localparam int unsigned DIV_SHIFT = 31 + DIV_LOG;
  localparam logic [TICK_W-1:0] DIV_MAGIC =
    TICK_W'((64'd1 << DIV_SHIFT) / 64'(TICKS_PER_SECOND));
  localparam logic [TICK_W-1:0] DIV_CONST = TICK_W'(TICKS_PER_SECOND);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_RUNNING = 3'b010,
    MODE_STOPPED = 3'b100
  } mode_t;

  typedef struct packed {
    logic               key_level;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               stop_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        timer_mode;
    logic              run_active;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [SEC_W-1:0]  elapsed_seconds;
  } out_item_t;

  typedef struct packed {
    logic [7:0] press_threshold;
    logic [7:0] stop_confirm_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        timer_mode;
    logic              run_active;
    logic [TICK_W-1:0] elapsed_ticks;
  } stage_t;

endpackage
`default_nettype wire

// File: design/lprt_core.sv
// Per-tick state update: stop request, key press counter and run timer.
// Depends on lprt_pkg for the item, configuration and stage types.
`default_nettype none
module lprt_core import lprt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output stage_t        st
);

  mode_t             mode_r, mode_nxt;
  logic              follow_r, follow_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] last_r, last_nxt;
  logic              seen_r, seen_nxt;
  logic [7:0]        still_r, still_nxt;
  logic [7:0]        press_r, press_nxt;
  logic              moving;

  always_comb begin
    mode_nxt = mode_r;
    follow_nxt = follow_r;
    tick_nxt = tick_r;
    last_nxt = last_r;
    seen_nxt = seen_r;
    still_nxt = still_r;
    press_nxt = press_r;
    moving = (item.left_speed != '0) || (item.right_speed != '0);

    if (item.stop_request) begin
      follow_nxt = 1'b0;
    end

    if (!item.key_level) begin
      if (press_r < PRESS_MAX) begin
        press_nxt = press_r + 8'd1;
      end
    end else if (press_r != '0) begin
      if (press_r > cfg.press_threshold) begin
        follow_nxt = 1'b1;
        if (mode_r != MODE_RUNNING) begin
          mode_nxt = MODE_RUNNING;
          tick_nxt = '0;
          last_nxt = '0;
          seen_nxt = 1'b0;
          still_nxt = '0;
        end
      end
      press_nxt = '0;
    end

    if (mode_nxt == MODE_RUNNING) begin
      if (!follow_nxt) begin
        mode_nxt = MODE_STOPPED;
      end else begin
        tick_nxt = tick_nxt + TICK_W'(1);
        if (moving) begin
          seen_nxt = 1'b1;
          still_nxt = '0;
          last_nxt = tick_nxt;
        end else if (seen_nxt) begin
          if (still_nxt < cfg.stop_confirm_ticks) begin
            still_nxt = still_nxt + 8'd1;
          end
          if (still_nxt >= cfg.stop_confirm_ticks) begin
            tick_nxt = last_nxt;
            mode_nxt = MODE_STOPPED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      follow_r <= 1'b0;
      tick_r <= '0;
      last_r <= '0;
      seen_r <= 1'b0;
      still_r <= '0;
      press_r <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      follow_r <= follow_nxt;
      tick_r <= tick_nxt;
      last_r <= last_nxt;
      seen_r <= seen_nxt;
      still_r <= still_nxt;
      press_r <= press_nxt;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_IDLE:    st.timer_mode = TM_IDLE;
      MODE_RUNNING: st.timer_mode = TM_RUNNING;
      MODE_STOPPED: st.timer_mode = TM_STOPPED;
      default:      st.timer_mode = TM_IDLE;
    endcase
    st.run_active = follow_r;
    st.elapsed_ticks = tick_r;
  end

endmodule
`default_nettype wire

// File: design/lprt_div.sv
// Three-stage pipeline that derives whole seconds from the tick count.
// Depends on lprt_pkg for the reciprocal constants and the stage and result types.
`default_nettype none
module lprt_div import lprt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   valid_in,
  input  wire stage_t stage_in,
  output logic        valid_out,
  output out_item_t   item_out
);

  logic                v2_r, v3_r, v4_r;
  stage_t              s2_r, s3_r;
  logic [2*TICK_W-1:0] prod_r;
  logic [TICK_W-1:0]   qest_r;
  logic [TICK_W-1:0]   qd_r;
  logic [TICK_W-1:0]   qest;
  logic [TICK_W-1:0]   rem;
  logic [TICK_W-1:0]   quot;
  out_item_t           out_r, out_nxt;

  assign qest = TICK_W'(prod_r >> DIV_SHIFT);
  assign rem = s3_r.elapsed_ticks - qd_r;
  assign quot = (rem >= DIV_CONST) ? qest_r + TICK_W'(1) : qest_r;

  always_comb begin
    out_nxt.timer_mode = s3_r.timer_mode;
    out_nxt.run_active = s3_r.run_active;
    out_nxt.elapsed_ticks = s3_r.elapsed_ticks;
    out_nxt.elapsed_seconds = quot[SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v2_r <= valid_in;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= stage_in;
      prod_r <= stage_in.elapsed_ticks * DIV_MAGIC;
      s3_r <= s2_r;
      qest_r <= qest;
      qd_r <= qest * DIV_CONST;
      out_r <= out_nxt;
    end
  end

  assign valid_out = v4_r;
  assign item_out = out_r;

endmodule
`default_nettype wire

// File: design/long_press_run_timer.sv
// Top level of the long-press run timer: handshakes, configuration registers
// and the pipeline made of lprt_core and lprt_div. Depends on lprt_pkg.
`default_nettype none
// One input transfer per 10 ms tick yields exactly one result transfer. The
// block takes a new tick every cycle while the result side keeps up; each
// tick's result is offered once it has passed the state registers, which
// take the tick at the transfer edge, and three further register stages
// that carry the reciprocal multiply that turns ticks into whole seconds.
// The whole pipeline holds while a result waits, so in_ready is low only
// while out_valid is high and out_ready is low. Configuration writes are
// always taken (cfg_ready is high); index 0 is press_threshold, index 1 is
// stop_confirm_ticks, and other indexes are ignored.
module long_press_run_timer import lprt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   adv;
  logic   in_fire;
  logic   s1_v_r;
  stage_t s1_st;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_fire = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_threshold <= PRESS_THRESHOLD_RST;
      cfg_r.stop_confirm_ticks <= STOP_CONFIRM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRESS_THRESHOLD: cfg_r.press_threshold <= cfg_data;
        CFG_STOP_CONFIRM:    cfg_r.stop_confirm_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_fire;
    end
  end

  lprt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (in_data),
    .cfg     (cfg_r),
    .st      (s1_st)
  );

  lprt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_in  (s1_v_r),
    .stage_in  (s1_st),
    .valid_out (out_valid),
    .item_out  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_mode == TM_IDLE |-> out_data.elapsed_ticks == '0)
    else $error("idle result with nonzero tick count");

  a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timer_mode == TM_RUNNING |-> out_data.run_active)
    else $error("running result without run flag");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.timer_mode != 2'd3)
    else $error("result carries an undefined mode code");
`endif

endmodule
`default_nettype wire
